FILE: sv/assert_macros.svh
// Assertion macros shared by the sorter RTL.
// Self-contained; no other file needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define KSS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a rising clock edge outside reset.
`define KSS_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: sv/kss_pkg.sv
// Shared types and constants of the k-sorted stream sorter.
// No dependencies.
package kss_pkg;

	localparam int VALUE_W = 32;
	localparam int WIN_W   = 5;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [WIN_W-1:0]          win_t;

	localparam win_t WIN_RESET = 5'd3;

endpackage

FILE: sv/kss_in_if.sv
// Input request channel of the sorter: one signed value and a last flag.
// Depends on kss_pkg.
interface kss_in_if;
	logic             valid;
	logic             ready;
	kss_pkg::value_t  in_value;
	logic             in_last;

	modport source (output valid, output in_value, output in_last, input ready);
	modport sink   (input valid, input in_value, input in_last, output ready);
endinterface

FILE: sv/kss_out_if.sv
// Result request channel of the sorter: one sorted value and a last flag.
// Depends on kss_pkg.
interface kss_out_if;
	logic             valid;
	logic             ready;
	kss_pkg::value_t  out_value;
	logic             out_last;

	modport source (output valid, output out_value, output out_last, input ready);
	modport sink   (input valid, input out_value, input out_last, output ready);
endinterface

FILE: sv/kss_cfg_if.sv
// Configuration write channel of the sorter: the window size register.
// Depends on kss_pkg.
interface kss_cfg_if;
	logic          valid;
	logic          ready;
	kss_pkg::win_t window_size;

	modport source (output valid, output window_size, input ready);
	modport sink   (input valid, input window_size, output ready);
endinterface

FILE: sv/kss_heap_mem.sv
// Heap storage: one write port, two read ports with registered read data.
// Depends on kss_pkg.
module kss_heap_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  kss_pkg::value_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr_a,
	input  logic [AW-1:0]   raddr_b,
	output kss_pkg::value_t rdata_a,
	output kss_pkg::value_t rdata_b
);

	kss_pkg::value_t heap_mem [DEPTH];
	kss_pkg::value_t rdata_a_q;
	kss_pkg::value_t rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			heap_mem[waddr] <= wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a_q <= heap_mem[raddr_a];
			rdata_b_q <= heap_mem[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

FILE: sv/kss_less.sv
// Shared signed comparator of the heap sequencer.
// Depends on kss_pkg.
module kss_less (
	input  kss_pkg::value_t a,
	input  kss_pkg::value_t b,
	output logic            lt
);

	assign lt = (a < b);

endmodule

FILE: sv/k_sorted_stream_sorter.sv
// k-sorted stream sorter: top level with the heap sequencer.
// Depends on kss_pkg, kss_in_if, kss_out_if, kss_cfg_if, kss_heap_mem,
// kss_less and assert_macros.svh.
//
// Usage: values arrive as requests on in_ch (in_value, in_last); sorted
// values leave as requests on out_ch (out_value, out_last). cfg_ch writes
// window_size (reset 3), always ready; write it only while the block is idle.
// While the heap holds fewer than min(window_size, MAX_WINDOW) entries a value
// without in_last is only inserted and gives no result; after that each value
// gives one result, the smallest of the heap and the new value. A value with
// in_last set gives that result and then drains the heap in ascending order,
// with out_last on the final result.
// Throughput: one value at a time; in_ch.ready is high only in the idle cycle.
// Busy states: an insert climbs through S_UP and S_UP_CMP; an emitting value
// meets the root in S_ROOT and, if the root is smaller, sifts down through
// S_DN, S_DN_LR and S_DN_CMP; each drained value passes S_POP and S_POP_EMIT
// and then sifts down. One comparator and one heap write port set these steps.
// Output: a result is loaded into the output register in S_EMIT, S_ROOT or
// S_POP_EMIT once it is free; it holds while out_ch stalls and the sequencer
// waits at its next result. Reset empties the heap (count only).
`include "assert_macros.svh"

module k_sorted_stream_sorter #(
	parameter int MAX_WINDOW = 31
) (
	input  logic      clk,
	input  logic      arst_n,
	kss_in_if.sink    in_ch,
	kss_out_if.source out_ch,
	kss_cfg_if.sink   cfg_ch
);

	localparam int HEAP_CAP = MAX_WINDOW + 1;
	localparam int IDX_W    = $clog2(HEAP_CAP);
	localparam int CNT_W    = $clog2(HEAP_CAP + 1);
	localparam int LW       = IDX_W + 2;
	localparam int CW       = (CNT_W > kss_pkg::WIN_W) ? CNT_W : kss_pkg::WIN_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP,
		S_UP_CMP,
		S_ROOT,
		S_EMIT,
		S_DN,
		S_DN_LR,
		S_DN_CMP,
		S_POP,
		S_POP_EMIT
	} state_t;

	state_t            state_q;
	kss_pkg::win_t     win_q;
	logic [CNT_W-1:0]  cnt_q;
	kss_pkg::value_t   val_q;      // value riding the hole
	logic              last_q;
	logic [IDX_W-1:0]  idx_q;      // hole position
	logic [IDX_W-1:0]  par_q;
	logic [IDX_W-1:0]  ch_idx_q;
	kss_pkg::value_t   ch_val_q;
	logic              out_valid_q;
	kss_pkg::value_t   out_value_q;
	logic              out_last_q;

	// heap memory port
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	kss_pkg::value_t   mem_wdata;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr_a;
	logic [IDX_W-1:0]  mem_raddr_b;
	kss_pkg::value_t   rd_a;
	kss_pkg::value_t   rd_b;

	// comparator
	kss_pkg::value_t   cmp_a;
	kss_pkg::value_t   cmp_b;
	logic              lt;

	logic [CW-1:0]     win_eff;
	logic              ins_only;
	logic              out_free;
	logic              out_load;
	logic [IDX_W-1:0]  par_of_idx;
	logic [IDX_W-1:0]  par_of_par;
	logic [LW-1:0]     cnt_w;
	logic [LW-1:0]     l_i_w;
	logic [LW-1:0]     r_i_w;
	logic [LW-1:0]     l_c_w;
	logic [LW-1:0]     r_c_w;
	logic [CNT_W-1:0]  cnt_m1;
	logic [CNT_W-1:0]  cnt_p1;

	// assertion helpers
	logic              ins_acc;
	logic              final_out;
	logic              rw_clash;

	kss_heap_mem #(
		.DEPTH (HEAP_CAP),
		.AW    (IDX_W)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	kss_less u_less (
		.a  (cmp_a),
		.b  (cmp_b),
		.lt (lt)
	);

	// Window in use is capped at MAX_WINDOW; insert only while below it.
	always_comb begin
		win_eff = (CW'(win_q) < CW'(MAX_WINDOW)) ? CW'(win_q) : CW'(MAX_WINDOW);
	end
	assign ins_only = (CW'(cnt_q) < win_eff);

	assign out_free   = !out_valid_q || out_ch.ready;
	assign out_load   = out_free && (state_q inside {S_EMIT, S_ROOT, S_POP_EMIT});
	assign par_of_idx = IDX_W'((idx_q - 1'b1) >> 1);
	assign par_of_par = IDX_W'((par_q - 1'b1) >> 1);
	assign cnt_w      = LW'(cnt_q);
	assign cnt_m1     = cnt_q - 1'b1;
	assign cnt_p1     = cnt_q + 1'b1;

	// Children of the hole and of the chosen child.
	assign l_i_w = {1'b0, idx_q, 1'b1};
	assign r_i_w = l_i_w + 1'b1;
	assign l_c_w = {1'b0, ch_idx_q, 1'b1};
	assign r_c_w = l_c_w + 1'b1;

	// Comparator operands per step.
	always_comb begin
		case (state_q)
			S_UP_CMP: begin
				cmp_a = val_q;
				cmp_b = rd_a;
			end
			S_ROOT: begin
				cmp_a = rd_a;
				cmp_b = val_q;
			end
			S_DN_LR: begin
				cmp_a = rd_b;
				cmp_b = rd_a;
			end
			S_DN_CMP: begin
				cmp_a = ch_val_q;
				cmp_b = val_q;
			end
			default: begin
				cmp_a = rd_a;
				cmp_b = val_q;
			end
		endcase
	end

	// Memory accesses per step.
	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = idx_q;
		mem_wdata   = val_q;
		mem_re      = 1'b0;
		mem_raddr_a = '0;
		mem_raddr_b = '0;
		case (state_q)
			S_IDLE: begin
				// fetch the root for a combined insert and extract
				if (in_ch.valid && !(ins_only && !in_ch.in_last) && cnt_q != '0) begin
					mem_re = 1'b1;
				end
			end
			S_UP: begin
				if (idx_q == '0) begin
					mem_we = 1'b1;
				end else begin
					mem_re      = 1'b1;
					mem_raddr_a = par_of_idx;
				end
			end
			S_UP_CMP: begin
				mem_we = 1'b1;
				if (lt) begin
					// move the parent down, fetch the next parent at once
					mem_wdata = rd_a;
					if (par_q != '0) begin
						mem_re      = 1'b1;
						mem_raddr_a = par_of_par;
					end
				end
			end
			S_DN: begin
				if (l_i_w >= cnt_w) begin
					mem_we = 1'b1;
				end else begin
					mem_re      = 1'b1;
					mem_raddr_a = l_i_w[IDX_W-1:0];
					mem_raddr_b = r_i_w[IDX_W-1:0];
				end
			end
			S_DN_CMP: begin
				mem_we = 1'b1;
				if (lt) begin
					// move the child up, fetch its children at once
					mem_wdata = ch_val_q;
					if (l_c_w < cnt_w) begin
						mem_re      = 1'b1;
						mem_raddr_a = l_c_w[IDX_W-1:0];
						mem_raddr_b = r_c_w[IDX_W-1:0];
					end
				end
			end
			S_POP: begin
				mem_re      = 1'b1;
				mem_raddr_b = cnt_m1[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// Sequencer: state and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			win_q       <= kss_pkg::WIN_RESET;
			cnt_q       <= '0;
			val_q       <= '0;
			last_q      <= 1'b0;
			idx_q       <= '0;
			par_q       <= '0;
			ch_idx_q    <= '0;
			ch_val_q    <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_ch.valid) begin
				win_q <= cfg_ch.window_size;
			end
			// load a new result, else drop the one taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						val_q  <= in_ch.in_value;
						last_q <= in_ch.in_last;
						if (ins_only && !in_ch.in_last) begin
							idx_q   <= cnt_q[IDX_W-1:0];
							cnt_q   <= cnt_p1;
							state_q <= S_UP;
						end else if (cnt_q == '0) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_ROOT;
						end
					end
				end
				S_UP: begin
					if (idx_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						par_q   <= par_of_idx;
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (lt) begin
						idx_q <= par_q;
						if (par_q != '0) begin
							par_q <= par_of_par;
						end else begin
							state_q <= S_UP;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_value_q <= val_q;
						out_last_q  <= last_q;
						state_q     <= S_IDLE;
					end
				end
				S_ROOT: begin
					if (out_free) begin
						out_last_q <= 1'b0;
						if (lt) begin
							// root is smaller: emit it, sift the new value from the top
							out_value_q <= rd_a;
							idx_q       <= '0;
							state_q     <= S_DN;
						end else begin
							out_value_q <= val_q;
							state_q     <= last_q ? S_POP : S_IDLE;
						end
					end
				end
				S_DN: begin
					if (l_i_w >= cnt_w) begin
						state_q <= last_q ? S_POP : S_IDLE;
					end else begin
						state_q <= S_DN_LR;
					end
				end
				S_DN_LR: begin
					if (r_i_w < cnt_w && lt) begin
						ch_idx_q <= r_i_w[IDX_W-1:0];
						ch_val_q <= rd_b;
					end else begin
						ch_idx_q <= l_i_w[IDX_W-1:0];
						ch_val_q <= rd_a;
					end
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (lt) begin
						idx_q   <= ch_idx_q;
						state_q <= (l_c_w < cnt_w) ? S_DN_LR : S_DN;
					end else begin
						state_q <= last_q ? S_POP : S_IDLE;
					end
				end
				S_POP: begin
					cnt_q   <= cnt_m1;
					state_q <= S_POP_EMIT;
				end
				S_POP_EMIT: begin
					if (out_free) begin
						out_value_q <= rd_a;
						out_last_q  <= (cnt_q == '0);
						val_q       <= rd_b;
						idx_q       <= '0;
						state_q     <= (cnt_q == '0) ? S_IDLE : S_DN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ch.ready      = (state_q == S_IDLE);
	assign cfg_ch.ready     = 1'b1;
	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_value = out_value_q;
	assign out_ch.out_last  = out_last_q;

	assign ins_acc   = in_ch.valid && in_ch.ready && !in_ch.in_last && ins_only;
	assign final_out = out_valid_q && out_last_q;
	assign rw_clash  = mem_we && mem_re &&
		(mem_waddr == mem_raddr_a || mem_waddr == mem_raddr_b);

	`KSS_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(MAX_WINDOW), "heap count above cap")
	`KSS_ASSERT(a_insert_grows, clk, arst_n, ins_acc |=> (cnt_q == $past(cnt_p1)), "heap did not grow")
	`KSS_ASSERT(a_last_empty, clk, arst_n, $rose(final_out) |-> (cnt_q == '0), "heap not empty at end")
	`KSS_NEVER(a_no_rw_clash, clk, arst_n, rw_clash, "heap read and write hit the same entry")

endmodule

FILE: test/kss_sort_checker.sv
`timescale 1ns / 1ps
// Scoreboard of the k-sorted stream sorter: watches the value, result and window
// channels, predicts the sorted results and compares them in order.
// Depends on kss_pkg, kss_in_if, kss_out_if and kss_cfg_if.
module kss_sort_checker #(
	parameter int MAX_WINDOW = 31
) (
	input  logic clk,
	input  logic arst_n,
	kss_in_if    in_ch,
	kss_out_if   out_ch,
	kss_cfg_if   cfg_ch,
	output int   mismatches,
	output int   pending
);

	typedef struct packed {
		kss_pkg::value_t value;
		logic            last;
	} sorted_result_t;

	kss_pkg::win_t   window;
	kss_pkg::value_t held_values[$];	// ascending, stands in for the heap
	sorted_result_t  sorted_due[$];

	// Append one owed result at the tail.
	function automatic void queue_result(input sorted_result_t r);
		sorted_due.insert(sorted_due.size(), r);
	endfunction

	// Insert the value; emit the minimum once the window is full, or drain on last.
	task automatic predict_sorted_results(input kss_pkg::value_t v, input logic last);
		int unsigned    count_before;
		int unsigned    win;
		int             pos;
		sorted_result_t r;
		count_before = held_values.size();
		win = (window < MAX_WINDOW) ? window : MAX_WINDOW;
		if (count_before < MAX_WINDOW + 1) begin
			pos = 0;
			while (pos < held_values.size() && held_values[pos] <= v)
				pos++;
			held_values.insert(pos, v);
		end
		if (last) begin
			while (held_values.size() > 0) begin
				r.value = held_values.pop_front();
				r.last  = (held_values.size() == 0);
				queue_result(r);
			end
		end else if (count_before >= win) begin
			r.value = held_values.pop_front();
			r.last  = 1'b0;
			queue_result(r);
		end
	endtask

	task automatic check_sorted_result(input kss_pkg::value_t v, input logic last);
		sorted_result_t want;
		if (sorted_due.size() == 0) begin
			$display("%0t: expected no result, actual value %0d last %0b", $time, v, last);
			mismatches++;
		end else begin
			want = sorted_due.pop_front();
			if (want.value !== v) begin
				$display("%0t: out_value expected %0d, actual %0d", $time, want.value, v);
				mismatches++;
			end
			if (want.last !== last) begin
				$display("%0t: out_last expected %0b, actual %0b", $time, want.last, last);
				mismatches++;
			end
		end
	endtask

	// Results are taken before new values: a result never stems from a value
	// accepted at the same edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			window = kss_pkg::WIN_RESET;
			held_values.delete();
			sorted_due.delete();
			mismatches = 0;
		end else begin
			if (out_ch.valid && out_ch.ready)
				check_sorted_result(out_ch.out_value, out_ch.out_last);
			if (cfg_ch.valid && cfg_ch.ready)
				window = cfg_ch.window_size;
			if (in_ch.valid && in_ch.ready)
				predict_sorted_results(in_ch.in_value, in_ch.in_last);
		end
		pending <= sorted_due.size();
	end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Top of the sorter testbench: clock, reset, request stimulus and the verdict.
// Depends on kss_pkg, the channel interfaces, k_sorted_stream_sorter and kss_sort_checker.
module testbench;

	localparam int MAX_WINDOW    = 31;
	localparam int RANDOM_ITEMS  = 90;
	localparam int GAP_LIMIT     = 6;
	// Covers an insert climbing all heap levels after the last result left.
	localparam int SETTLE_CYCLES = 40;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   sent;
	int   in_gap_max;
	int   out_stall_max;

	kss_in_if  in_ch ();
	kss_out_if out_ch ();
	kss_cfg_if cfg_ch ();

	k_sorted_stream_sorter #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	// The checker sees every handshake and reports what is still owed.
	kss_sort_checker #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_ch    (cfg_ch),
		.mismatches(mismatches),
		.pending   (pending)
	);

	always #10 clk = ~clk;

	// Stop a hung run.
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Send one value request: idle for a drawn gap, then hold it until accepted.
	// With no gap, valid stays high and only the payload moves on.
	task automatic send_value(input kss_pkg::value_t v, input logic last);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.in_value <= v;
		in_ch.in_last  <= last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	// Drop valid, wait for every owed result, then let a pending insert finish.
	task automatic settle();
		@(negedge clk) in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the window register; call only after settle.
	task automatic write_window(input kss_pkg::win_t ws);
		@(negedge clk);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.window_size <= ws;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk) cfg_ch.valid <= 1'b0;
	endtask

	// A nearly ascending run with small jitter, sprinkled with wild values and
	// extremes. Without terminate the heap is left holding values.
	task automatic send_stream(input int len, input bit terminate);
		kss_pkg::value_t base;
		kss_pkg::value_t v;
		int              jitter;
		int              offset;
		base   = $urandom;
		jitter = $urandom_range(0, 64);
		for (int i = 0; i < len; i++) begin
			offset = int'($urandom_range(0, 2 * jitter)) - jitter;
			case ($urandom_range(0, 15))
				0:       v = $urandom;
				1:       v = 32'sh7FFF_FFFF;
				2:       v = 32'sh8000_0000;
				default: v = base + kss_pkg::value_t'(i * 16 + offset);
			endcase
			send_value(v, terminate && (i == len - 1));
		end
	endtask

	// Result side: draw a stall per request, then hold ready until one is taken.
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		forever begin
			stall = $urandom_range(0, out_stall_max);
			if (stall > 0) begin
				@(negedge clk) out_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid)
				@(posedge clk);
		end
	end

	initial begin
		int            start;
		int            phase;
		int            streams;
		int            len;
		kss_pkg::win_t ws;
		clk                = 1'b0;
		arst_n             = 1'b0;
		in_ch.valid        = 1'b0;
		in_ch.in_value     = '0;
		in_ch.in_last      = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.window_size = '0;
		in_gap_max         = GAP_LIMIT;
		out_stall_max      = GAP_LIMIT;
		sent               = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Extremes with the reset window of three: the fourth and fifth values
		// emit, the last one drains the remaining four.
		send_value(32'sh7FFF_FFFF, 1'b0);
		send_value(32'sh8000_0000, 1'b0);
		send_value(0, 1'b0);
		send_value(-1, 1'b0);
		send_value(1, 1'b0);
		send_value(7, 1'b1);
		// Last before the heap fills, then last into an empty heap.
		send_value(42, 1'b0);
		send_value(-42, 1'b1);
		send_value(9, 1'b1);

		// Zero window: output mirrors input.
		settle();
		write_window(5'd0);
		send_value(3, 1'b0);
		send_value(-3, 1'b1);

		// Equal values.
		settle();
		write_window(5'd2);
		send_value(5, 1'b0);
		send_value(5, 1'b0);
		send_value(5, 1'b1);

		// Shrink while the heap holds four: 15 still emits exactly one, 25 drains all five.
		settle();
		write_window(5'd4);
		send_value(10, 1'b0);
		send_value(40, 1'b0);
		send_value(30, 1'b0);
		send_value(20, 1'b0);
		settle();
		write_window(5'd1);
		send_value(15, 1'b0);
		send_value(25, 1'b1);

		// Grow while one is held: insert only until the heap reaches three.
		settle();
		write_window(5'd1);
		send_value(8, 1'b0);
		send_value(6, 1'b0);
		settle();
		write_window(5'd3);
		send_value(4, 1'b0);
		send_value(2, 1'b0);
		send_value(0, 1'b1);

		// Random phases: each picks a window and an idling style, then sends
		// a few streams. The widest window gets one long stream only.
		start = sent;
		phase = 0;
		while (sent - start < RANDOM_ITEMS) begin
			case (phase % 5)
				1:       ws = 5'd0;
				2:       ws = 5'd31;
				3:       ws = 5'd1;
				default: ws = kss_pkg::win_t'($urandom_range(0, 31));
			endcase
			settle();
			write_window(ws);
			in_gap_max    = $urandom_range(0, 1) ? GAP_LIMIT : 0;
			out_stall_max = $urandom_range(0, 1) ? GAP_LIMIT : 0;
			streams = (ws == 31) ? 1 : $urandom_range(1, 3);
			repeat (streams) begin
				len = (ws == 31) ? $urandom_range(34, 40) : $urandom_range(1, int'(ws) + 6);
				send_stream(len, $urandom_range(0, 3) != 0);
			end
			phase++;
		end
		// Flush whatever a broken stream left behind.
		send_value($urandom, 1'b1);

		settle();
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: k_sorted_stream_sorter.f
+incdir+sv
sv/kss_pkg.sv
sv/kss_in_if.sv
sv/kss_out_if.sv
sv/kss_cfg_if.sv
sv/kss_heap_mem.sv
sv/kss_less.sv
sv/k_sorted_stream_sorter.sv
test/kss_sort_checker.sv
test/testbench.sv
